// ===== rtl/sorted_key_table_defines.svh =====
// Assertion macros for the sorted key table sequencer (skt_ctrl).
`ifndef SORTED_KEY_TABLE_DEFINES_SVH
`define SORTED_KEY_TABLE_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define SKT_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sorted_key_table: assertion failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define SKT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sorted_key_table: assertion failed");

`endif

// ===== rtl/skt_pkg.sv =====
// Types, constants and state codes for the sorted key table.
`timescale 1ns / 1ps
package skt_pkg;

  localparam int CAPACITY = 64;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int KEY_W    = 32;
  localparam int VAL_W    = 32;
  localparam int COUNT_W  = 7;

  localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

  localparam logic [2:0] OP_FIND       = 3'd0;
  localparam logic [2:0] OP_ADD        = 3'd1;
  localparam logic [2:0] OP_REMOVE     = 3'd2;
  localparam logic [2:0] OP_ITER_RESET = 3'd3;
  localparam logic [2:0] OP_ITER_NEXT  = 3'd4;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;
  localparam logic [1:0] ST_ENDED     = 2'd3;

  typedef struct packed {
    logic [2:0]       operation;
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] value;
  } req_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [KEY_W-1:0]   out_key;
    logic [VAL_W-1:0]   out_value;
    logic [COUNT_W-1:0] entry_count;
  } rsp_t;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] value;
  } entry_t;

  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] addr;
    entry_t           data;
  } mem_wr_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_SEARCH,
    S_SEARCH_CMP,
    S_MATCH,
    S_MOVE_RD,
    S_MOVE_WR,
    S_ITER_RD,
    S_DONE
  } state_t;

endpackage

// ===== rtl/skt_store.sv =====
// Entry memory: one write port and one registered read port.
`timescale 1ns / 1ps
module skt_store (
  input  logic                               clk,
  input  skt_pkg::mem_wr_t                   wr,
  input  logic [skt_pkg::IDX_W-1:0]          raddr,
  output skt_pkg::entry_t                    rdata
);
  import skt_pkg::*;

  entry_t mem [CAPACITY];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/skt_ctrl.sv =====
// Sequencer: binary search, entry shifting and iteration over the entry memory.
`timescale 1ns / 1ps
`include "sorted_key_table_defines.svh"
module skt_ctrl (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  skt_pkg::req_t             req,
  input  logic                      res_free,
  output logic                      ready,
  output logic                      done,
  output skt_pkg::rsp_t             result,
  output skt_pkg::mem_wr_t          wr,
  output logic [skt_pkg::IDX_W-1:0] raddr,
  input  skt_pkg::entry_t           rdata
);
  import skt_pkg::*;

  state_t           state;
  state_t           state_next;
  logic [2:0]       op;
  logic [KEY_W-1:0] key;
  logic [VAL_W-1:0] val;
  logic [1:0]       status;
  logic [KEY_W-1:0] okey;
  logic [VAL_W-1:0] oval;
  logic [CNT_W-1:0] lo;
  logic [CNT_W-1:0] hi;
  logic [CNT_W-1:0] cur;
  logic [CNT_W-1:0] held;
  logic [CNT_W-1:0] iter;

  logic [CNT_W:0]   sum;
  logic [CNT_W-1:0] mid;
  logic [CNT_W-1:0] hi_m1;
  logic [CNT_W-1:0] src;
  logic             is_add;
  logic             more;
  logic             key_le;

  assign sum    = {1'b0, lo} + {1'b0, hi};
  assign mid    = sum[CNT_W:1];
  assign hi_m1  = hi - 1'b1;
  assign is_add = (op == OP_ADD);
  // Add moves entries up from the top down; remove pulls them down from the gap up.
  assign src    = is_add ? (cur - 1'b1) : (cur + 1'b1);
  assign more   = is_add ? (cur > hi) : (src < held);
  assign key_le = (rdata.key <= key);

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (start) state_next = S_DISPATCH;
      end
      S_DISPATCH: begin
        case (op)
          OP_FIND, OP_REMOVE: state_next = S_SEARCH;
          OP_ADD:             state_next = (held >= CAP_CNT) ? S_DONE : S_SEARCH;
          OP_ITER_NEXT:       state_next = (iter < held) ? S_ITER_RD : S_DONE;
          default:            state_next = S_DONE;
        endcase
      end
      S_SEARCH: begin
        if (lo < hi) begin
          state_next = S_SEARCH_CMP;
        end else if (is_add) begin
          state_next = S_MOVE_RD;
        end else begin
          state_next = (hi == '0) ? S_DONE : S_MATCH;
        end
      end
      S_SEARCH_CMP: state_next = S_SEARCH;
      S_MATCH: begin
        state_next = (rdata.key == key && op == OP_REMOVE) ? S_MOVE_RD : S_DONE;
      end
      S_MOVE_RD: state_next = more ? S_MOVE_WR : S_DONE;
      S_MOVE_WR: state_next = S_MOVE_RD;
      S_ITER_RD: state_next = S_DONE;
      S_DONE: begin
        if (res_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Memory port and handshake outputs.
  always_comb begin
    raddr   = '0;
    wr.en   = 1'b0;
    wr.addr = '0;
    wr.data = rdata;
    ready   = (state == S_IDLE);
    done    = (state == S_DONE);
    case (state)
      S_DISPATCH: raddr = iter[IDX_W-1:0];
      S_SEARCH:   raddr = (lo < hi) ? mid[IDX_W-1:0] : hi_m1[IDX_W-1:0];
      S_MOVE_RD: begin
        raddr = src[IDX_W-1:0];
        if (is_add && !more) begin
          wr.en         = 1'b1;
          wr.addr       = hi[IDX_W-1:0];
          wr.data.key   = key;
          wr.data.value = val;
        end
      end
      S_MOVE_WR: begin
        wr.en   = 1'b1;
        wr.addr = cur[IDX_W-1:0];
      end
      default: raddr = '0;
    endcase
  end

  assign result.status      = status;
  assign result.out_key     = okey;
  assign result.out_value   = oval;
  assign result.entry_count = COUNT_W'(held);

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      held  <= '0;
      iter  <= '0;
    end else begin
      state <= state_next;
      case (state)
        S_DISPATCH: begin
          if (op == OP_ITER_RESET) iter <= '0;
        end
        S_MOVE_RD: begin
          if (!more) begin
            held <= is_add ? (held + 1'b1) : (held - 1'b1);
          end
        end
        S_ITER_RD: iter <= iter + 1'b1;
        default: ;
      endcase
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (start) begin
          op     <= req.operation;
          key    <= req.key;
          val    <= req.value;
          status <= ST_OK;
          okey   <= req.key;
          oval   <= '0;
        end
      end
      S_DISPATCH: begin
        lo  <= '0;
        hi  <= held;
        cur <= held;
        if (op == OP_ADD && held >= CAP_CNT) status <= ST_FULL;
        if (op == OP_ITER_NEXT && !(iter < held)) status <= ST_ENDED;
      end
      S_SEARCH: begin
        if (!(lo < hi) && !is_add && hi == '0) status <= ST_NOT_FOUND;
      end
      S_SEARCH_CMP: begin
        if (key_le) lo <= mid + 1'b1;
        else        hi <= mid;
      end
      S_MATCH: begin
        if (rdata.key == key) begin
          oval <= rdata.value;
          cur  <= hi_m1;
        end else begin
          status <= ST_NOT_FOUND;
        end
      end
      S_MOVE_WR: cur <= src;
      S_ITER_RD: begin
        okey <= rdata.key;
        oval <= rdata.value;
      end
      default: ;
    endcase
  end

  `SKT_ASSERT_NOW(a_held_bound, 1'b1, held <= CAP_CNT)
  `SKT_ASSERT_NOW(a_search_range, state == S_SEARCH_CMP, lo < hi)
  `SKT_ASSERT_NOW(a_write_window, wr.en, state == S_MOVE_RD || state == S_MOVE_WR)
  `SKT_ASSERT_NEXT(a_done_release, state == S_DONE && res_free, state == S_IDLE)

endmodule

// ===== rtl/sorted_key_table.sv =====
// Top level of the sorted key table: request intake, sequencer, memory, result register.
//
// Usage: a request item (operation, key, value) enters on req when req_valid and
// req_ready are high at a rising edge of clk. Exactly one result item (status,
// out_key, out_value, entry_count) leaves on rsp for each request, in order.
// Operations are find, add, remove, iterator reset and iterator next.
// Sequencing: find, remove and an add into a table that is not full go through
// a binary search over the entry memory in halving steps (a read through the
// single memory read port, then a compare). Add and remove then shift the
// entries above the insert or remove point by one place, with one read and one
// write per moved entry. Iterator next reads at most one entry and iterator
// reset reads none. One request is in work at a time.
// Stalls: the result register holds a finished item until rsp_ready; the next
// request is accepted meanwhile, and its own result waits in the sequencer
// until the register frees up.
// Reset: rst clears the entry count and the iterator; the memory is not cleared.
`timescale 1ns / 1ps
module sorted_key_table (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_ready,
  input  skt_pkg::req_t  req,
  output logic           rsp_valid,
  input  logic           rsp_ready,
  output skt_pkg::rsp_t  rsp
);
  import skt_pkg::*;

  logic             start;
  logic             res_free;
  logic             done;
  rsp_t             result;
  mem_wr_t          wr;
  logic [IDX_W-1:0] raddr;
  entry_t           rdata;

  assign start    = req_valid && req_ready;
  assign res_free = !rsp_valid || rsp_ready;

  skt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .req      (req),
    .res_free (res_free),
    .ready    (req_ready),
    .done     (done),
    .result   (result),
    .wr       (wr),
    .raddr    (raddr),
    .rdata    (rdata)
  );

  skt_store u_store (
    .clk   (clk),
    .wr    (wr),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (done && res_free) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done && res_free) begin
      rsp <= result;
    end
  end

endmodule
